FILE: rtl/eul_pkg.sv
`timescale 1ns / 1ps
package eul_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int ENTRY_BITS = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int LATENCY = CORDIC_STEPS + 6;

  localparam logic [0:0] REG_AXIS_ORDER = 1'b0;
  localparam logic [0:0] REG_ROTATION_KIND = 1'b1;

  localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam logic signed [69:0] ENTRY_ONE = 70'sd1 <<< (ENTRY_BITS - 2);

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic [1:0] ax_first;
    logic [1:0] ax_mid;
    logic [1:0] ax_last;
    logic       transpose;
  } ctl_t;

  function automatic logic [5:0] order_axes(input logic [3:0] order);
    logic [5:0] r;
    case (order)
      4'd1: r = {2'd2, 2'd0, 2'd1};
      4'd2: r = {2'd1, 2'd2, 2'd0};
      4'd3: r = {2'd1, 2'd0, 2'd2};
      4'd4: r = {2'd0, 2'd2, 2'd1};
      4'd5: r = {2'd0, 2'd1, 2'd2};
      4'd6: r = {2'd2, 2'd1, 2'd2};
      4'd7: r = {2'd2, 2'd0, 2'd2};
      4'd8: r = {2'd0, 2'd2, 2'd0};
      4'd9: r = {2'd0, 2'd1, 2'd0};
      4'd10: r = {2'd1, 2'd2, 2'd1};
      4'd11: r = {2'd1, 2'd0, 2'd1};
      default: r = {2'd2, 2'd1, 2'd0};
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] elem_entry(input logic [1:0] axis, input int i,
                                                    input int j,
                                                    input logic signed [31:0] c,
                                                    input logic signed [31:0] s);
    logic [1:0] p;
    logic signed [32:0] r;
    p = (axis == 2'd2) ? 2'd0 : axis + 2'd1;
    if (i == int'(axis) && j == int'(axis)) r = Q30_ONE;
    else if (i == int'(axis) || j == int'(axis)) r = '0;
    else if (i == j) r = 33'(c);
    else if (i == int'(p)) r = -33'(s);
    else r = 33'(s);
    return r;
  endfunction

  function automatic logic signed [69:0] round_shift(input logic signed [69:0] v,
                                                     input int s);
    logic signed [69:0] half;
    logic signed [69:0] mag;
    half = 70'sd1 <<< (s - 1);
    mag = -v + half;
    if (!v[69]) return (v + half) >>> s;
    return -(mag >>> s);
  endfunction

endpackage

FILE: rtl/eul_sincos.sv
`timescale 1ns / 1ps
module eul_sincos (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [2:0][eul_pkg::ANGLE_BITS-1:0] angles,
  input  logic                            negate,
  input  eul_pkg::ctl_t                   ctl_in,
  output logic                            out_valid,
  output eul_pkg::ctl_t                   ctl_out,
  output logic [2:0][31:0]                cos_q,
  output logic [2:0][31:0]                sin_q
);

  localparam int N = eul_pkg::CORDIC_STEPS;

  logic               vld [N+1];
  eul_pkg::ctl_t      ctl [N+1];
  logic signed [32:0] cx [N+1][3];
  logic signed [32:0] cy [N+1][3];
  logic signed [32:0] cz [N+1][3];
  logic [1:0]         qd [N+1][3];

  logic [2:0][31:0] turn;
  logic [2:0][31:0] shifted;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      turn[k] = 32'(angles[k]) << (32 - eul_pkg::ANGLE_BITS);
      if (negate) turn[k] = 32'd0 - turn[k];
      shifted[k] = turn[k] + 32'h2000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g <= N; g++) vld[g] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int g = 0; g < N; g++) vld[g+1] <= vld[g];
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0] <= ctl_in;
      for (int k = 0; k < 3; k++) begin
        cx[0][k] <= eul_pkg::CORDIC_START;
        cy[0][k] <= '0;
        cz[0][k] <= $signed({3'b000, shifted[k][29:0]}) - 33'sh2000_0000;
        qd[0][k] <= shifted[k][31:30];
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        ctl[g+1] <= ctl[g];
        for (int k = 0; k < 3; k++) begin
          qd[g+1][k] <= qd[g][k];
          if (!cz[g][k][32]) begin
            cx[g+1][k] <= cx[g][k] - (cy[g][k] >>> g);
            cy[g+1][k] <= cy[g][k] + (cx[g][k] >>> g);
            cz[g+1][k] <= cz[g][k] - $signed({1'b0, eul_pkg::ATAN_TURNS[g]});
          end else begin
            cx[g+1][k] <= cx[g][k] + (cy[g][k] >>> g);
            cy[g+1][k] <= cy[g][k] - (cx[g][k] >>> g);
            cz[g+1][k] <= cz[g][k] + $signed({1'b0, eul_pkg::ATAN_TURNS[g]});
          end
        end
      end
    end
  end

  logic signed [32:0] co [3];
  logic signed [32:0] si [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (qd[N][k])
        2'd0: begin co[k] = cx[N][k]; si[k] = cy[N][k]; end
        2'd1: begin co[k] = -cy[N][k]; si[k] = cx[N][k]; end
        2'd2: begin co[k] = -cx[N][k]; si[k] = -cy[N][k]; end
        default: begin co[k] = cy[N][k]; si[k] = -cx[N][k]; end
      endcase
      if (co[k] > eul_pkg::Q30_ONE) co[k] = eul_pkg::Q30_ONE;
      if (co[k] < -eul_pkg::Q30_ONE) co[k] = -eul_pkg::Q30_ONE;
      if (si[k] > eul_pkg::Q30_ONE) si[k] = eul_pkg::Q30_ONE;
      if (si[k] < -eul_pkg::Q30_ONE) si[k] = -eul_pkg::Q30_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out <= ctl[N];
      for (int k = 0; k < 3; k++) begin
        cos_q[k] <= co[k][31:0];
        sin_q[k] <= si[k][31:0];
      end
    end
  end

endmodule

FILE: rtl/eul_matmul.sv
`timescale 1ns / 1ps
module eul_matmul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  eul_pkg::ctl_t                       ctl_in,
  input  logic [2:0][31:0]                    cos_q,
  input  logic [2:0][31:0]                    sin_q,
  output logic                                out_valid,
  output logic [8:0][eul_pkg::ENTRY_BITS-1:0] entries
);

  localparam int OUT_SHIFT = 30 - (eul_pkg::ENTRY_BITS - 2);

  logic [3:0] vld;
  eul_pkg::ctl_t ctl_a, ctl_b, ctl_c, ctl_d;
  logic signed [65:0] pa [3][3][3];
  logic signed [33:0] t [3][3];
  logic signed [32:0] el [3][3];
  logic signed [32:0] el_b [3][3];
  logic signed [66:0] pc [3][3][3];
  logic signed [34:0] r [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [69:0] acc;
    logic signed [69:0] v;
    if (en) begin
      ctl_a <= ctl_in;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          el[i][j] <= eul_pkg::elem_entry(ctl_in.ax_last, i, j, $signed(cos_q[2]),
                                          $signed(sin_q[2]));
          for (int k = 0; k < 3; k++)
            pa[i][j][k] <= eul_pkg::elem_entry(ctl_in.ax_mid, i, k, $signed(cos_q[1]),
                                               $signed(sin_q[1]))
                         * eul_pkg::elem_entry(ctl_in.ax_first, k, j, $signed(cos_q[0]),
                                               $signed(sin_q[0]));
        end
      ctl_b <= ctl_a;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 70'(pa[i][j][0]) + 70'(pa[i][j][1]) + 70'(pa[i][j][2]);
          t[i][j] <= 34'(eul_pkg::round_shift(acc, 30));
          el_b[i][j] <= el[i][j];
        end
      ctl_c <= ctl_b;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            pc[i][j][k] <= el_b[i][k] * t[k][j];
      ctl_d <= ctl_c;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 70'(pc[i][j][0]) + 70'(pc[i][j][1]) + 70'(pc[i][j][2]);
          r[i][j] <= 35'(eul_pkg::round_shift(acc, 30));
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          v = ctl_d.transpose ? 70'(r[j][i]) : 70'(r[i][j]);
          v = eul_pkg::round_shift(v, OUT_SHIFT);
          if (v > eul_pkg::ENTRY_ONE) v = eul_pkg::ENTRY_ONE;
          if (v < -eul_pkg::ENTRY_ONE) v = -eul_pkg::ENTRY_ONE;
          entries[i*3+j] <= v[eul_pkg::ENTRY_BITS-1:0];
        end
    end
  end

endmodule

FILE: rtl/euler_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Converts three Euler angles into a 3x3 rotation matrix of Q1.14 entries.
// The input channel (in_valid, in_stall) carries first_angle, middle_angle
// and last_angle as binary angles; a transfer happens when in_valid is high
// and in_stall is low. The output channel (out_valid, out_stall) carries the
// nine entries m00 to m22 in row-major order.
// The configuration channel (cfg_valid, cfg_ready) writes axis_order at index
// 0 and rotation_kind at index 1; cfg_ready is always high. Write it only
// while no item is in flight.
// From the input transfer to the result, an item passes the angle setup
// register loaded at the transfer edge, then 30 CORDIC stages, one for quadrant
// folding and five for the two matrix products and the final rounding.
// One item can be taken every cycle while in_stall is low.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall goes high in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and sets both registers to zero.
module euler_to_rotation_matrix (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [eul_pkg::ANGLE_BITS-1:0] first_angle,
  input  logic signed [eul_pkg::ANGLE_BITS-1:0] middle_angle,
  input  logic signed [eul_pkg::ANGLE_BITS-1:0] last_angle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [eul_pkg::ENTRY_BITS-1:0] m00,
  output logic signed [eul_pkg::ENTRY_BITS-1:0] m01,
  output logic signed [eul_pkg::ENTRY_BITS-1:0] m02,
  output logic signed [eul_pkg::ENTRY_BITS-1:0] m10,
  output logic signed [eul_pkg::ENTRY_BITS-1:0] m11,
  output logic signed [eul_pkg::ENTRY_BITS-1:0] m12,
  output logic signed [eul_pkg::ENTRY_BITS-1:0] m20,
  output logic signed [eul_pkg::ENTRY_BITS-1:0] m21,
  output logic signed [eul_pkg::ENTRY_BITS-1:0] m22,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [3:0] axis_order;
  logic [1:0] rotation_kind;
  logic en;
  logic [5:0] axes;
  eul_pkg::ctl_t ctl_in, ctl_mid;
  logic sc_valid;
  logic [2:0][31:0] cos_q, sin_q;
  logic [8:0][eul_pkg::ENTRY_BITS-1:0] entries;

  assign cfg_ready = 1'b1;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_order <= '0;
      rotation_kind <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        eul_pkg::REG_AXIS_ORDER: axis_order <= cfg_data[3:0];
        eul_pkg::REG_ROTATION_KIND: rotation_kind <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign axes = eul_pkg::order_axes(axis_order);
  assign ctl_in = '{ax_first: axes[5:4], ax_mid: axes[3:2], ax_last: axes[1:0],
                    transpose: rotation_kind[0] ^ rotation_kind[1]};

  eul_sincos u_sincos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .angles    ({last_angle, middle_angle, first_angle}),
    .negate    (rotation_kind[0]),
    .ctl_in    (ctl_in),
    .out_valid (sc_valid),
    .ctl_out   (ctl_mid),
    .cos_q     (cos_q),
    .sin_q     (sin_q)
  );

  eul_matmul u_matmul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sc_valid),
    .ctl_in    (ctl_mid),
    .cos_q     (cos_q),
    .sin_q     (sin_q),
    .out_valid (out_valid),
    .entries   (entries)
  );

  assign m00 = entries[0];
  assign m01 = entries[1];
  assign m02 = entries[2];
  assign m10 = entries[3];
  assign m11 = entries[4];
  assign m12 = entries[5];
  assign m20 = entries[6];
  assign m21 = entries[7];
  assign m22 = entries[8];

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");
  a_m00_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m00 <= 16'sd16384 && m00 >= -16'sd16384))
    else $error("m00 out of range");
  a_m11_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m11 <= 16'sd16384 && m11 >= -16'sd16384))
    else $error("m11 out of range");
  a_cfg_axis: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index == eul_pkg::REG_AXIS_ORDER |=> axis_order == $past(cfg_data[3:0]))
    else $error("axis order write lost");

endmodule

FILE: sim/euler_to_rotation_matrix_checker.sv
`timescale 1ns / 1ps
module euler_to_rotation_matrix_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic signed [eul_pkg::ANGLE_BITS-1:0] first_angle,
  input  logic signed [eul_pkg::ANGLE_BITS-1:0] middle_angle,
  input  logic signed [eul_pkg::ANGLE_BITS-1:0] last_angle,
  input  logic out_valid,
  input  logic out_stall,
  input  logic signed [eul_pkg::ENTRY_BITS-1:0] m00,
  input  logic signed [eul_pkg::ENTRY_BITS-1:0] m01,
  input  logic signed [eul_pkg::ENTRY_BITS-1:0] m02,
  input  logic signed [eul_pkg::ENTRY_BITS-1:0] m10,
  input  logic signed [eul_pkg::ENTRY_BITS-1:0] m11,
  input  logic signed [eul_pkg::ENTRY_BITS-1:0] m12,
  input  logic signed [eul_pkg::ENTRY_BITS-1:0] m20,
  input  logic signed [eul_pkg::ENTRY_BITS-1:0] m21,
  input  logic signed [eul_pkg::ENTRY_BITS-1:0] m22,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int   errors,
  output int   pending
);

  typedef longint mat_t [3][3];
  typedef struct {
    logic signed [eul_pkg::ENTRY_BITS-1:0] e [9];
  } matrix_t;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint ARCTAN [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  logic [3:0] order_q;
  logic [1:0] kind_q;
  matrix_t    expected_matrices [$];

  function automatic longint round_away(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic void cos_sin(logic [31:0] turn, output longint co, output longint si);
    logic [31:0] shifted;
    longint x, y, z, nx;
    shifted = turn + 32'h2000_0000;
    z = longint'({34'd0, shifted[29:0]}) - 64'sh2000_0000;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
    end
    case (shifted[31:30])
      2'd0: begin co = x; si = y; end
      2'd1: begin co = -y; si = x; end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
    co = clamp_unit(co);
    si = clamp_unit(si);
  endfunction

  function automatic mat_t axis_rotation(int axis, logic [31:0] turn);
    mat_t m;
    longint c, s;
    int p, q;
    cos_sin(turn, c, s);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = 0;
    p = (axis + 1) % 3;
    q = (axis + 2) % 3;
    m[axis][axis] = ONE_Q30;
    m[p][p] = c;
    m[q][q] = c;
    m[p][q] = -s;
    m[q][p] = s;
    return m;
  endfunction

  function automatic mat_t mat_mul(mat_t a, mat_t b);
    mat_t r;
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += a[i][k] * b[k][j];
        r[i][j] = round_away(acc, 30);
      end
    return r;
  endfunction

  function automatic matrix_t rotation_of(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                                          logic [3:0] order, logic [1:0] kind);
    matrix_t res;
    logic [31:0] t0, t1, t2;
    int ax0, ax1, ax2;
    bit neg, trn;
    mat_t prod;
    longint v;
    t0 = {a0, 16'd0};
    t1 = {a1, 16'd0};
    t2 = {a2, 16'd0};
    case (order)
      4'd1: begin ax0 = 2; ax1 = 0; ax2 = 1; end
      4'd2: begin ax0 = 1; ax1 = 2; ax2 = 0; end
      4'd3: begin ax0 = 1; ax1 = 0; ax2 = 2; end
      4'd4: begin ax0 = 0; ax1 = 2; ax2 = 1; end
      4'd5: begin ax0 = 0; ax1 = 1; ax2 = 2; end
      4'd6: begin ax0 = 2; ax1 = 1; ax2 = 2; end
      4'd7: begin ax0 = 2; ax1 = 0; ax2 = 2; end
      4'd8: begin ax0 = 0; ax1 = 2; ax2 = 0; end
      4'd9: begin ax0 = 0; ax1 = 1; ax2 = 0; end
      4'd10: begin ax0 = 1; ax1 = 2; ax2 = 1; end
      4'd11: begin ax0 = 1; ax1 = 0; ax2 = 1; end
      default: begin ax0 = 2; ax1 = 1; ax2 = 0; end
    endcase
    neg = (kind == 2'd1) || (kind == 2'd3);
    trn = (kind == 2'd1) || (kind == 2'd2);
    if (neg) begin
      t0 = 32'd0 - t0;
      t1 = 32'd0 - t1;
      t2 = 32'd0 - t2;
    end
    prod = mat_mul(axis_rotation(ax2, t2),
                   mat_mul(axis_rotation(ax1, t1), axis_rotation(ax0, t0)));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v = trn ? prod[j][i] : prod[i][j];
        v = round_away(v, 30 - (eul_pkg::ENTRY_BITS - 2));
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        res.e[i * 3 + j] = v[eul_pkg::ENTRY_BITS-1:0];
      end
    return res;
  endfunction

  task automatic report(string what, int idx, logic signed [15:0] want,
                        logic signed [15:0] got);
    $display("%0t mismatch: %s entry %0d expected %0d got %0d", $time, what, idx, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    matrix_t seen, want;
    if (rst) begin
      order_q <= '0;
      kind_q <= '0;
      expected_matrices.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_matrices.push_back(rotation_of(first_angle, middle_angle, last_angle,
                                                order_q, kind_q));
      if (out_valid && !out_stall) begin
        seen.e = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        if (expected_matrices.size() == 0) begin
          report("unexpected transfer", 0, 0, m00);
        end else begin
          want = expected_matrices.pop_front();
          for (int i = 0; i < 9; i++)
            if (seen.e[i] !== want.e[i]) report("matrix", i, want.e[i], seen.e[i]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == eul_pkg::REG_AXIS_ORDER) order_q <= cfg_data[3:0];
        else if (cfg_index == eul_pkg::REG_ROTATION_KIND) kind_q <= cfg_data[1:0];
      end
    end
    pending <= expected_matrices.size();
  end

endmodule

FILE: sim/euler_to_rotation_matrix_test.sv
`timescale 1ns / 1ps
module euler_to_rotation_matrix_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [eul_pkg::ANGLE_BITS-1:0] first_angle = '0;
  logic signed [eul_pkg::ANGLE_BITS-1:0] middle_angle = '0;
  logic signed [eul_pkg::ANGLE_BITS-1:0] last_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [eul_pkg::ENTRY_BITS-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = eul_pkg::REG_AXIS_ORDER;
  logic [7:0] cfg_data = '0;
  int errors;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  euler_to_rotation_matrix dut (.*);
  euler_to_rotation_matrix_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_request = 1'b0;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_angles(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2);
    in_valid <= 1'b1;
    first_angle <= a0;
    middle_angle <= a1;
    last_angle <= a2;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (eul_pkg::LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(7)) << 13;
      4: return 16'($urandom_range(7) << 13) + 16'($signed($urandom_range(6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] extremes [6];
    extremes = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h0001};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 6; i++)
      send_angles(extremes[i], extremes[(i + 1) % 6], extremes[(i + 3) % 6]);
    send_angles(16'h2000, 16'hE000, 16'h1555);
    send_angles(16'hFFFF, 16'h8001, 16'h7FFF);
    wait_drained();
    // Writes with high bits set; the axis code is one of the unused ones.
    write_register(eul_pkg::REG_AXIS_ORDER, 8'hFD);
    write_register(eul_pkg::REG_ROTATION_KIND, 8'hFF);
    for (int i = 0; i < 6; i++)
      send_angles(extremes[(i + 2) % 6], extremes[i], extremes[(i + 5) % 6]);
    wait_drained();
    write_register(eul_pkg::REG_AXIS_ORDER, 8'd11);
    write_register(eul_pkg::REG_ROTATION_KIND, 8'd1);
    for (int i = 0; i < 5; i++)
      send_angles(extremes[i], 16'h8000, extremes[5 - i]);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 80 : 0;
      recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 13 : 0;
      for (int seg = 0; seg < 8; seg++) begin
        wait_drained();
        write_register(eul_pkg::REG_AXIS_ORDER, (seg == 0) ? 8'd0 : (seg == 1) ? 8'd11 :
                       8'({$urandom_range(15), 4'($urandom)}));
        write_register(eul_pkg::REG_ROTATION_KIND, (seg < 4) ? 8'(seg) : 8'($urandom));
        if (phase == 2 && seg == 0) hold_request = 1'b1;
        for (int n = 0; n < 66; n++)
          send_angles(pick_angle(), pick_angle(), pick_angle());
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/eul_pkg.sv
rtl/eul_sincos.sv
rtl/eul_matmul.sv
rtl/euler_to_rotation_matrix.sv
sim/euler_to_rotation_matrix_checker.sv
sim/euler_to_rotation_matrix_test.sv
